// File: sv/alpha_boundary_pixel_detector_core_macros.svh
// Assertion macros of the alpha boundary pixel detector, used by abpd_emit.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ALPHA_BOUNDARY_PIXEL_DETECTOR_CORE_MACROS_SVH
`define ALPHA_BOUNDARY_PIXEL_DETECTOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ABPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define ABPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ABPD_ASSERT_IMP(lbl, ante, cons, msg)

`define ABPD_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// File: sv/abpd_pkg.sv
// Shared constants, register codes and types of the alpha boundary pixel detector.
// Used by every module of the block but abpd_ram; depends on nothing.
`default_nettype none

package abpd_pkg;

  localparam int MaxWidth  = 2048;
  localparam int MaxHeight = 2048;

  localparam int CoordW  = 11;
  localparam int DimW    = 12;
  localparam int ThrW    = 8;
  localparam int CfgIdxW = 2;
  localparam int AddrW   = $clog2(MaxWidth);

  localparam logic [ThrW-1:0] ThrReset = ThrW'(127);

  typedef enum logic [CfgIdxW-1:0] {
    CfgThreshold = 2'd0,
    CfgWidth     = 2'd1,
    CfgHeight    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [ThrW-1:0] thr;
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic prev_opq;
    logic older_opq;
  } ent_t;

  localparam int EntW = $bits(ent_t);

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              cur;
    logic              self_opq;
    logic              up_opq;
    logic              left_opq;
    logic              border;
    logic              last_col;
    logic              last_row;
    logic              has_above;
  } item_t;

endpackage

`default_nettype wire

// File: sv/abpd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
`default_nettype none

module abpd_ram #(
  parameter int Width = 1,
  parameter int Depth = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: sv/abpd_cfg.sv
// Configuration registers of the detector, with clamping of the frame size.
// Depends on abpd_pkg.
`default_nettype none

module abpd_cfg
  import abpd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [DimW-1:0]    cfg_data_i,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q, cfg_d;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                input logic [DimW-1:0] maxv);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgThreshold: cfg_d.thr    = cfg_data_i[ThrW-1:0];
        CfgWidth:     cfg_d.width  = clamp_dim(cfg_data_i, DimW'(MaxWidth));
        CfgHeight:    cfg_d.height = clamp_dim(cfg_data_i, DimW'(MaxHeight));
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.thr    <= ThrReset;
      cfg_q.width  <= DimW'(MaxWidth);
      cfg_q.height <= DimW'(MaxHeight);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: sv/abpd_scan.sv
// Raster counters and the two-row line buffer of opaque flags.
// Depends on abpd_pkg and abpd_ram.
`default_nettype none

module abpd_scan
  import abpd_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic [ThrW-1:0] alpha_i,
  input  cfg_t                 cfg_i,
  output item_t                item_o,
  output logic                 right_o
);

  logic [CoordW-1:0] col_q, col_d;
  logic [CoordW-1:0] row_q, row_d;
  logic              fwd_q;
  ent_t              fwd_data_q;
  logic              left_q;

  ent_t              ram_rdata;
  ent_t              win;
  ent_t              wdata;
  logic [AddrW-1:0]  waddr;
  logic [AddrW-1:0]  raddr;
  logic [CoordW-1:0] next_col;
  logic              cur;
  logic              last_col;
  logic              last_row;
  logic              above_border;

  // The read issued with the previous transfer fetched this column; a write to the
  // same column at that edge (one-pixel rows) is taken from the forward register.
  assign win = fwd_q ? fwd_data_q : ram_rdata;

  assign cur          = alpha_i > cfg_i.thr;
  assign last_col     = DimW'(col_q) >= (cfg_i.width - DimW'(1));
  assign last_row     = DimW'(row_q) >= (cfg_i.height - DimW'(1));
  assign above_border = (row_q == CoordW'(1)) || (DimW'(row_q) >= cfg_i.height);
  assign next_col     = last_col ? '0 : col_q + CoordW'(1);

  assign waddr          = col_q[AddrW-1:0];
  assign raddr          = next_col[AddrW-1:0];
  assign wdata.prev_opq  = cur;
  assign wdata.older_opq = win.prev_opq;

  abpd_ram #(
    .Width(EntW),
    .Depth(MaxWidth)
  ) u_line_buf (
    .clk_i  (clk_i),
    .we_i   (accept_i),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (accept_i),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      col_d = next_col;
      if (last_col) begin
        row_d = last_row ? '0 : row_q + CoordW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      fwd_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (accept_i) begin
        fwd_q <= waddr == raddr;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      fwd_data_q <= wdata;
      left_q     <= win.prev_opq;
    end
  end

  assign item_o.x         = col_q;
  assign item_o.y         = row_q;
  assign item_o.cur       = cur;
  assign item_o.self_opq  = win.prev_opq;
  assign item_o.up_opq    = win.older_opq;
  assign item_o.left_opq  = left_q;
  assign item_o.border    = above_border || (col_q == '0) || last_col;
  assign item_o.last_col  = last_col;
  assign item_o.last_row  = last_row;
  assign item_o.has_above = row_q != '0;

  assign right_o = ram_rdata.prev_opq;

endmodule

`default_nettype wire

// File: sv/abpd_emit.sv
// Pixel stage and result register: classifies the pixel above and the pixel itself.
// Depends on abpd_pkg and the assertion macro header.
`default_nettype none

`include "alpha_boundary_pixel_detector_core_macros.svh"

module abpd_emit
  import abpd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  item_t                   item_i,
  input  wire logic               right_i,
  input  wire logic               out_stall_i,
  output logic                    free_o,
  output logic                    out_valid_o,
  output logic      [CoordW-1:0]  out_pix_x_o,
  output logic      [CoordW-1:0]  out_pix_y_o,
  output logic                    out_is_edge_o,
  output logic                    out_frame_done_o,
  output logic                    out_last_o
);

  item_t             item_q;
  logic [1:0]        mask_q, mask_d, mask_after;
  logic              out_valid_q, out_valid_d;
  logic [CoordW-1:0] out_x_q, out_y_q;
  logic              out_edge_q, out_done_q, out_last_q;

  logic              has_res;
  logic              sel_own;
  logic              load;
  logic              above_edge;

  // Bit 0 is the result for the pixel above, bit 1 the pixel's own result.
  assign has_res = mask_q != 2'b00;
  assign sel_own = !mask_q[0];
  assign load    = has_res && (!out_valid_q || !out_stall_i);

  assign above_edge = item_q.self_opq && (item_q.border || !item_q.left_opq || !right_i ||
                                          !item_q.up_opq || !item_q.cur);

  always_comb begin
    mask_after = mask_q;
    if (load) begin
      mask_after = mask_q[0] ? {mask_q[1], 1'b0} : 2'b00;
    end
  end

  assign free_o = mask_after == 2'b00;

  always_comb begin
    mask_d = mask_after;
    if (accept_i) begin
      mask_d = {item_i.last_row, item_i.has_above};
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= 2'b00;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      item_q <= item_i;
    end
    if (load) begin
      out_x_q    <= item_q.x;
      out_y_q    <= sel_own ? item_q.y : item_q.y - CoordW'(1);
      out_edge_q <= sel_own ? item_q.cur : above_edge;
      out_done_q <= sel_own && item_q.last_col;
      out_last_q <= sel_own || !item_q.last_row;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_pix_x_o      = out_x_q;
  assign out_pix_y_o      = out_y_q;
  assign out_is_edge_o    = out_edge_q;
  assign out_frame_done_o = out_done_q;
  assign out_last_o       = out_last_q;

  `ABPD_ASSERT_IMP(a_done_is_last, out_valid_q && out_done_q, out_last_q, "frame end result not last")
  `ABPD_ASSERT_IMP(a_own_pending, out_valid_q && !out_last_q, mask_q[1], "own result missing")
  `ABPD_ASSERT_NXT(a_two_step, (mask_q == 2'b11) && load, mask_q == 2'b10, "result order broken")

endmodule

`default_nettype wire

// File: sv/alpha_boundary_pixel_detector_core.sv
// Alpha boundary pixel detector. Alpha pixels enter in raster order, one per cycle,
// and each transfer emits the result for the pixel directly above it (from the
// second row on) and, on the last row, the pixel's own result after it. A pixel is
// accepted every cycle while the output is taken; a last-row pixel yields two results
// through the single result register, so there no new pixel is taken until both are
// loaded. A pixel is held in the pixel stage, its results then in the result register.
// Opaque flags of two rows live in one MaxWidth-entry, two-bit RAM with one write and
// one read per transfer; it needs no clearing after reset. The user must write frame
// size and threshold only while the block is idle; the block does not enforce it.
`default_nettype none

module alpha_boundary_pixel_detector_core
  import abpd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [DimW-1:0]    cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [ThrW-1:0]    in_alpha_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic      [CoordW-1:0]  out_pix_x_o,
  output logic      [CoordW-1:0]  out_pix_y_o,
  output logic                    out_is_edge_o,
  output logic                    out_frame_done_o,
  output logic                    out_last_o
);

  cfg_t  cfg;
  item_t item;
  logic  right;
  logic  free;
  logic  accept;

  assign in_stall_o = !free;
  assign accept     = in_valid_i && free;

  abpd_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .cfg_o     (cfg)
  );

  abpd_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .alpha_i (in_alpha_i),
    .cfg_i   (cfg),
    .item_o  (item),
    .right_o (right)
  );

  abpd_emit u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .item_i          (item),
    .right_i         (right),
    .out_stall_i     (out_stall_i),
    .free_o          (free),
    .out_valid_o     (out_valid_o),
    .out_pix_x_o     (out_pix_x_o),
    .out_pix_y_o     (out_pix_y_o),
    .out_is_edge_o   (out_is_edge_o),
    .out_frame_done_o(out_frame_done_o),
    .out_last_o      (out_last_o)
  );

endmodule

`default_nettype wire
